// ----- rtl/core/assert_macros.svh -----
// Assertion helpers used by the checker file ple_checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A condition that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error(msg);

// A temporal property, checked at every clock edge outside reset.
`define ASSERT_PROP(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

`endif

// ----- rtl/core/ple_pkg.sv -----
package ple_pkg;

    // Input command codes.
    localparam logic CMD_TICK  = 1'b0;
    localparam logic CMD_WRITE = 1'b1;

    // Internal segment index width; table_length can reach 31.
    localparam int SEG_W = 5;

    // trunc(n / 100) = (n * DIV_RECIP) >> DIV_SHIFT for every n below 2**23.
    localparam logic [23:0] DIV_RECIP = 24'd10737419;
    localparam int          DIV_SHIFT = 30;

    typedef struct packed {
        logic               command;
        logic [3:0]         entry_index;
        logic [7:0]         entry_base;
        logic [7:0]         entry_steps;
        logic signed [15:0] entry_slope;
    } in_item_t;

    typedef struct packed {
        logic [7:0] brightness;
        logic [3:0] segment_now;
        logic [7:0] step_now;
    } out_item_t;

    // One table entry: slope in the upper half, then steps, then base.
    typedef struct packed {
        logic signed [15:0] slope;
        logic [7:0]         steps;
        logic [7:0]         base;
    } seg_t;

    // Everything the arithmetic needs for one tick.
    typedef struct packed {
        logic [7:0]         base;
        logic signed [15:0] slope;
        logic [7:0]         step;
        logic [3:0]         seg_idx;
    } slice_t;

endpackage

// ----- rtl/core/piecewise_linear_envelope.sv -----
// A tick's result moves from a_reg through the b and c registers to the output
// register. Throughput: one transaction per cycle while item_stall is low, ticks
// and table writes alike; the segment table is a single memory with one write and
// one registered read each cycle. A table write yields no result. Reset (rst_n,
// asynchronous, active low) clears the sequencer state, the table length and the
// pipeline; table contents are undefined until written.
module piecewise_linear_envelope
    import ple_pkg::*;
#(
    parameter int TABLE_DEPTH = 16
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       item_valid,
    output logic       item_stall,
    input  in_item_t   item,
    output logic       result_valid,
    input  logic       result_stall,
    output out_item_t  result,
    input  logic       table_length_we,
    input  logic [4:0] table_length_data
);

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    seg_t             mem [TABLE_DEPTH];
    seg_t             rdata_reg;
    seg_t             cur_reg;
    logic             started_reg;
    logic             pending_reg;
    logic [SEG_W-1:0] seg_idx_reg;
    logic [7:0]       step_reg;
    logic [4:0]       table_length_reg;
    logic             a_valid_reg;
    slice_t           a_reg;

    logic             unit_ready;
    logic             tick_acc;
    logic             wr_acc;
    logic             mem_we;
    logic [AW-1:0]    wr_addr;
    seg_t             wr_data;
    logic [4:0]       len_eff;
    seg_t             seg_src;
    logic [SEG_W-1:0] idx_use;
    logic [7:0]       step_use;
    logic [7:0]       step_inc;
    logic             adv;
    logic [SEG_W:0]   idx_inc;
    logic [SEG_W-1:0] next_idx;
    logic             load_now;
    logic             rd_en;
    logic [AW-1:0]    rd_addr;
    logic             started_next;
    logic             pending_next;
    logic [SEG_W-1:0] seg_idx_next;
    logic [7:0]       step_next;
    slice_t           a_next;

    assign item_stall = a_valid_reg && !unit_ready;
    assign tick_acc   = item_valid && !item_stall && (item.command == CMD_TICK);
    assign wr_acc     = item_valid && !item_stall && (item.command == CMD_WRITE);
    assign mem_we     = wr_acc && (32'(item.entry_index) < TABLE_DEPTH);
    assign wr_addr    = AW'(item.entry_index);
    assign wr_data    = '{slope: item.entry_slope, steps: item.entry_steps,
                          base: item.entry_base};

    always_comb
    begin
        len_eff = (32'(table_length_reg) > TABLE_DEPTH) ? 5'(TABLE_DEPTH)
                                                         : table_length_reg;
        // Until the first tick, and after a load, the segment sits in the read register.
        seg_src  = (pending_reg || !started_reg) ? rdata_reg : cur_reg;
        idx_use  = started_reg ? seg_idx_reg : '0;
        step_use = started_reg ? step_reg : 8'd0;
        step_inc = step_use + 8'd1;
        adv      = (step_inc == seg_src.steps);
        idx_inc  = {1'b0, idx_use} + 1'b1;
        next_idx = (idx_inc >= {{(SEG_W + 1 - 5){1'b0}}, len_eff}) ? '0
                                                                      : idx_inc[SEG_W-1:0];

        started_next = started_reg;
        pending_next = pending_reg;
        seg_idx_next = seg_idx_reg;
        step_next    = step_reg;
        load_now     = 1'b0;

        a_next.base    = 8'd0;
        a_next.slope   = 16'sd0;
        a_next.step    = 8'd0;
        a_next.seg_idx = 4'd0;

        if (tick_acc)
        begin
            if (len_eff == 5'd0)
            begin
                started_next = 1'b0;
            end
            else
            begin
                started_next   = 1'b1;
                load_now       = adv;
                pending_next   = adv;
                seg_idx_next   = adv ? next_idx : idx_use;
                step_next      = adv ? 8'd0 : step_inc;
                a_next.base    = seg_src.base;
                a_next.slope   = seg_src.slope;
                a_next.step    = step_use;
                a_next.seg_idx = idx_use[3:0];
            end
        end

        // While stopped, keep entry 0 fresh so the first tick can use it at once.
        rd_en   = load_now || !started_next;
        rd_addr = load_now ? AW'(next_idx) : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            started_reg      <= 1'b0;
            pending_reg      <= 1'b0;
            seg_idx_reg      <= '0;
            step_reg         <= 8'd0;
            table_length_reg <= 5'd0;
            a_valid_reg      <= 1'b0;
        end
        else
        begin
            started_reg <= started_next;
            pending_reg <= pending_next;
            seg_idx_reg <= seg_idx_next;
            step_reg    <= step_next;
            if (table_length_we)
            begin
                table_length_reg <= table_length_data;
            end
            if (!item_stall)
            begin
                a_valid_reg <= tick_acc;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (tick_acc)
        begin
            a_reg <= a_next;
            if (len_eff != 5'd0)
            begin
                cur_reg <= seg_src;
            end
        end
    end

    // Segment table: one write port, one registered read port with write forwarding.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            if (mem_we && (wr_addr == rd_addr))
            begin
                rdata_reg <= wr_data;
            end
            else
            begin
                rdata_reg <= mem[rd_addr];
            end
        end
    end

    ple_slope_unit u_slope_unit (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (a_valid_reg),
        .in_ready     (unit_ready),
        .in_slice     (a_reg),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule

// ----- rtl/core/ple_slope_unit.sv -----
module ple_slope_unit
    import ple_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  slice_t    in_slice,
    output logic      result_valid,
    input  logic      result_stall,
    output out_item_t result
);

    logic               b_valid_reg;
    logic signed [23:0] b_prod_reg;
    logic [7:0]         b_base_reg;
    logic [7:0]         b_step_reg;
    logic [3:0]         b_idx_reg;

    logic               c_valid_reg;
    logic [7:0]         c_quot_reg;
    logic               c_neg_reg;
    logic [7:0]         c_base_reg;
    logic [7:0]         c_step_reg;
    logic [3:0]         c_idx_reg;

    logic               out_valid_reg;
    out_item_t          out_reg;

    logic               ready_out;
    logic               ready_c;
    logic               ready_b;
    logic signed [23:0] prod_next;
    logic               neg_next;
    logic [22:0]        mag_next;
    logic [46:0]        recip_next;
    logic [7:0]         quot_signed;
    out_item_t          out_next;

    assign ready_out = !out_valid_reg || !result_stall;
    assign ready_c   = !c_valid_reg || ready_out;
    assign ready_b   = !b_valid_reg || ready_c;
    assign in_ready  = ready_b;

    always_comb
    begin
        prod_next  = in_slice.slope * $signed({1'b0, in_slice.step});
        neg_next   = b_prod_reg[23];
        mag_next   = 23'(neg_next ? -b_prod_reg : b_prod_reg);
        recip_next = {24'd0, mag_next} * {23'd0, DIV_RECIP};
        // Only the low byte of the quotient survives the final wrap to 8 bits.
        quot_signed          = c_neg_reg ? (8'd0 - c_quot_reg) : c_quot_reg;
        out_next.brightness  = c_base_reg + quot_signed;
        out_next.segment_now = c_idx_reg;
        out_next.step_now    = c_step_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg   <= 1'b0;
            c_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (ready_b)
            begin
                b_valid_reg <= in_valid;
            end
            if (ready_c)
            begin
                c_valid_reg <= b_valid_reg;
            end
            if (ready_out)
            begin
                out_valid_reg <= c_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready_b && in_valid)
        begin
            b_prod_reg <= prod_next;
            b_base_reg <= in_slice.base;
            b_step_reg <= in_slice.step;
            b_idx_reg  <= in_slice.seg_idx;
        end
        if (ready_c && b_valid_reg)
        begin
            c_quot_reg <= recip_next[DIV_SHIFT + 7:DIV_SHIFT];
            c_neg_reg  <= neg_next;
            c_base_reg <= b_base_reg;
            c_step_reg <= b_step_reg;
            c_idx_reg  <= b_idx_reg;
        end
        if (ready_out && c_valid_reg)
        begin
            out_reg <= out_next;
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

endmodule

// ----- rtl/core/ple_checker.sv -----
`include "assert_macros.svh"

module ple_checker
    import ple_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       item_valid,
    input logic       item_stall,
    input in_item_t   item,
    input logic       result_valid,
    input logic       result_stall,
    input out_item_t  result,
    input logic       table_length_we,
    input logic [4:0] table_length_data
);

    logic tick_acc;
    logic out_held;
    logic out_free;

    assign tick_acc = item_valid && !item_stall && (item.command == CMD_TICK);
    assign out_held = result_valid && result_stall;
    assign out_free = !result_stall;

    sequence s_tick_free;
        tick_acc ##1 out_free [*3];
    endsequence

    // The input side backs up only when every stage is full and the output is held.
    `ASSERT_ALWAYS(a_stall_needs_full, clk, rst_n, !item_stall || out_held, "input stalled early")

    // With the output free over the span in s_tick_free, an accepted tick reaches the output.
    `ASSERT_PROP(a_tick_latency, clk, rst_n, (s_tick_free |=> result_valid), "tick result late")

    `ASSERT_PROP(a_result_held, clk, rst_n, (out_held |=> result_valid), "result dropped")

    `ASSERT_PROP(a_result_stable, clk, rst_n, (out_held |=> $stable(result)), "result changed")

endmodule

bind piecewise_linear_envelope ple_checker u_ple_checker (.*);
